// ===== design/gsag_pkg.sv =====
// Shared types and constants for the gather stick address generator.
package gsag_pkg;

  // Number of coordinate slots held by the position counter.
  localparam int unsigned COORD_SLOTS = 4;
  localparam int unsigned COORD_W     = 16;
  localparam int unsigned SKIP_W      = 24;
  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned CFG_INDEX_W = 4;

  // A coordinate or in-bounds index times a skip.
  localparam int unsigned PROD_W = COORD_W + SKIP_W;
  // Base plus one index term plus one term per coordinate slot.
  localparam int unsigned SUM_W  = PROD_W + 3;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_BASE_STICK      = 4'd0,
    REG_GATHER_DIM      = 4'd1,
    REG_GATHER_DIM_SIZE = 4'd2,
    REG_SHAPE_SIZES     = 4'd3,
    REG_DIM_SKIP_0      = 4'd4,
    REG_DIM_SKIP_1      = 4'd5,
    REG_DIM_SKIP_2      = 4'd6,
    REG_DIM_SKIP_3      = 4'd7
  } cfg_reg_t;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BOUNDS   = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } status_t;

  // One gather index item.
  typedef struct packed {
    logic signed [31:0] index_value;
    logic               restart;
  } idx_item_t;

  // One stick address result.
  typedef struct packed {
    logic [ADDR_W-1:0] stick_address;
    status_t           status;
  } addr_item_t;

endpackage

// ===== design/gather_stick_address_generator.sv =====
// Gather stick address generator: coordinate counter and two-stage address pipeline.
//
// Usage: gather index values arrive on the idx channel in row-major order of the
// index tensor; each transfer yields exactly one stick address on the addr channel.
// A transfer happens at a clock edge where valid is high and stall is low.
// Set restart on the first item of a tensor to clear the coordinate counter.
// Stage one forms the five 16x24 products (one per coordinate slot plus the
// index term) and the bounds check; stage two adds them to the base, checks for
// overflow past 32 bits and holds the result in the output register.
// An idx transfer is registered in stage one and then in the output register, which
// drives the matching addr transfer. Throughput is one item per cycle while the receiver
// does not stall, set by the counter update and the product registers.
// When the receiver stalls, the output register holds its result, stage one holds
// its item, and idx stall rises once stage one is full, so no item is lost.
// Configuration registers are written through cfg_write/cfg_index/cfg_data; the user
// writes them only while the block is idle (not enforced); indexes above seven are ignored.
// Reset (rst, synchronous) empties the pipeline, clears the coordinate counter and
// returns the registers to their defaults: gather_dim_size 1, all others 0.
module gather_stick_address_generator
  import gsag_pkg::*;
#(
  parameter int unsigned MAX_DIMS = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   idx_valid,
  output logic                   idx_stall,
  input  idx_item_t              idx_item,
  output logic                   addr_valid,
  input  logic                   addr_stall,
  output addr_item_t             addr_item,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int unsigned ACTIVE_DIMS = (MAX_DIMS < COORD_SLOTS) ? MAX_DIMS : COORD_SLOTS;

  // Configuration registers.
  logic [ADDR_W-1:0]     base_stick;
  logic [1:0]            gather_dim;
  logic [COORD_W-1:0]    gather_dim_size;
  logic [CFG_DATA_W-1:0] shape_sizes;
  logic [SKIP_W-1:0]     dim_skip [COORD_SLOTS];

  // Coordinate counter.
  logic [COORD_W-1:0] coords      [COORD_SLOTS];
  logic [COORD_W-1:0] coords_eff  [COORD_SLOTS];
  logic [COORD_W-1:0] coords_next [COORD_SLOTS];

  // Stage one registers.
  logic              s1_valid;
  logic [PROD_W-1:0] s1_prod [COORD_SLOTS];
  logic [PROD_W-1:0] s1_idx_prod;
  logic              s1_bounds;

  // Stage one inputs.
  logic [PROD_W-1:0] prod [COORD_SLOTS];
  logic [PROD_W-1:0] idx_prod;
  logic              out_of_bounds;

  // Stage two sum.
  logic [SUM_W-1:0] sum;
  logic             overflow;

  logic idx_accept;
  logic out_ready;

  // Handshake: the output register frees when empty or taken; stage one moves with it.
  assign out_ready  = !addr_valid || !addr_stall;
  assign idx_stall  = s1_valid && !out_ready;
  assign idx_accept = idx_valid && !idx_stall;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      base_stick      <= '0;
      gather_dim      <= '0;
      gather_dim_size <= COORD_W'(1);
      shape_sizes     <= '0;
      for (int k = 0; k < COORD_SLOTS; k++) begin
        dim_skip[k] <= '0;
      end
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BASE_STICK:      base_stick      <= cfg_data[ADDR_W-1:0];
        REG_GATHER_DIM:      gather_dim      <= cfg_data[1:0];
        REG_GATHER_DIM_SIZE: gather_dim_size <= cfg_data[COORD_W-1:0];
        REG_SHAPE_SIZES:     shape_sizes     <= cfg_data;
        REG_DIM_SKIP_0:      dim_skip[0]     <= cfg_data[SKIP_W-1:0];
        REG_DIM_SKIP_1:      dim_skip[1]     <= cfg_data[SKIP_W-1:0];
        REG_DIM_SKIP_2:      dim_skip[2]     <= cfg_data[SKIP_W-1:0];
        REG_DIM_SKIP_3:      dim_skip[3]     <= cfg_data[SKIP_W-1:0];
        default: ;
      endcase
    end
  end

  // Coordinates seen by this item, after an optional restart.
  always_comb begin
    for (int k = 0; k < COORD_SLOTS; k++) begin
      coords_eff[k] = idx_item.restart ? '0 : coords[k];
    end
  end

  // Mixed-radix advance: the last active dimension counts fastest, size 0 acts as 1.
  always_comb begin
    logic             carry;
    logic [COORD_W:0] nxt;
    carry = 1'b1;
    nxt   = '0;
    for (int k = 0; k < COORD_SLOTS; k++) begin
      coords_next[k] = coords_eff[k];
    end
    for (int d = COORD_SLOTS - 1; d >= 0; d--) begin
      if (d < ACTIVE_DIMS && carry) begin
        nxt = {1'b0, coords_eff[d]} + (COORD_W+1)'(1);
        if (nxt >= {1'b0, shape_sizes[CFG_DATA_W-1-COORD_W*d -: COORD_W]}) begin
          coords_next[d] = '0;
        end else begin
          coords_next[d] = nxt[COORD_W-1:0];
          carry = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < COORD_SLOTS; k++) begin
        coords[k] <= '0;
      end
    end else if (idx_accept) begin
      coords <= coords_next;
    end
  end

  // Stage one products and bounds check; the gathered dimension takes the index.
  always_comb begin
    out_of_bounds = idx_item.index_value[31] ||
                    (32'(idx_item.index_value) >= {16'd0, gather_dim_size});
    idx_prod = out_of_bounds ? '0 :
               PROD_W'(idx_item.index_value[COORD_W-1:0]) * PROD_W'(dim_skip[gather_dim]);
    for (int k = 0; k < COORD_SLOTS; k++) begin
      if (k < ACTIVE_DIMS && 2'(k) != gather_dim) begin
        prod[k] = PROD_W'(coords_eff[k]) * PROD_W'(dim_skip[k]);
      end else begin
        prod[k] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!s1_valid || out_ready) begin
      s1_valid <= idx_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (idx_accept) begin
      s1_prod     <= prod;
      s1_idx_prod <= idx_prod;
      s1_bounds   <= out_of_bounds;
    end
  end

  // Stage two sum and overflow check.
  always_comb begin
    sum = SUM_W'(base_stick) + SUM_W'(s1_idx_prod);
    for (int k = 0; k < COORD_SLOTS; k++) begin
      sum = sum + SUM_W'(s1_prod[k]);
    end
    overflow = |sum[SUM_W-1:ADDR_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      addr_valid <= 1'b0;
    end else if (out_ready) begin
      addr_valid <= s1_valid;
    end
  end

  // Output register; the address is zero whenever the status is not ok.
  always_ff @(posedge clk) begin
    if (out_ready && s1_valid) begin
      if (s1_bounds) begin
        addr_item.stick_address <= '0;
        addr_item.status        <= STATUS_BOUNDS;
      end else if (overflow) begin
        addr_item.stick_address <= '0;
        addr_item.status        <= STATUS_OVERFLOW;
      end else begin
        addr_item.stick_address <= sum[ADDR_W-1:0];
        addr_item.status        <= STATUS_OK;
      end
    end
  end

  // An error result never carries an address.
  assert property (@(posedge clk) disable iff (rst)
    addr_valid && addr_item.status != STATUS_OK |-> addr_item.stick_address == '0)
    else $error("error result carries a nonzero address");

  // A full stage one facing a stalled output must back-pressure the input.
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && addr_valid && addr_stall |-> idx_stall)
    else $error("input not stalled while pipeline is blocked");

  // An item leaving stage one lands in the output register.
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_ready |=> addr_valid)
    else $error("item lost between stage one and output");

  // After a restart the fastest coordinate is zero or one.
  assert property (@(posedge clk) disable iff (rst)
    idx_accept && idx_item.restart |=> coords[ACTIVE_DIMS-1] <= COORD_W'(1))
    else $error("counter did not restart");

endmodule

// ===== sim/gather_stick_address_generator_tb.sv =====
// Self-checking testbench for the gather stick address generator.
`timescale 1ns / 100ps

module gather_stick_address_generator_tb
  import gsag_pkg::*;
();

  localparam int MAX_DIMS    = 4;
  localparam int ACTIVE_DIMS = (MAX_DIMS < COORD_SLOTS) ? MAX_DIMS : COORD_SLOTS;

  localparam int unsigned TARGET_ITEMS     = 1950;
  localparam int unsigned CYCLE_LIMIT      = 400000;
  localparam int unsigned LONG_HOLD_CYCLES = 60;
  localparam int unsigned MAX_REPORTS      = 10;
  localparam int unsigned CFG_FIRST_UNUSED = 8;
  localparam int unsigned CFG_LAST_INDEX   = (1 << CFG_INDEX_W) - 1;

  // One queued index transfer and the idle cycles the sender waits before it.
  typedef struct {
    idx_item_t   item;
    int unsigned gap;
  } index_entry_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   idx_valid = 1'b0;
  logic                   idx_stall;
  idx_item_t              idx_item = '0;
  logic                   addr_valid;
  logic                   addr_stall = 1'b0;
  addr_item_t             addr_item;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // Shadow copy of the configuration and the coordinate counter.
  logic [31:0]  base_m  = '0;
  logic [1:0]   gdim_m  = '0;
  logic [15:0]  gsize_m = 16'd1;
  logic [63:0]  shape_m = '0;
  logic [23:0]  skip_m  [COORD_SLOTS] = '{default: '0};
  logic [15:0]  coord_m [COORD_SLOTS] = '{default: '0};

  index_entry_t index_fifo[$];
  addr_item_t   stick_addr_queue[$];
  index_entry_t stage;
  bit           staged = 1'b0;

  int unsigned gap_max = 0;
  int unsigned stall_max = 0;
  int unsigned stall_left = 0;
  int unsigned long_hold_left = 0;
  bit          long_hold_req = 1'b0;

  int unsigned error_count = 0;
  int unsigned items_queued = 0;
  int unsigned items_sent = 0;
  int unsigned results_checked = 0;
  int unsigned ok_seen = 0;
  int unsigned bounds_seen = 0;
  int unsigned overflow_seen = 0;
  int unsigned settings_applied = 0;
  int unsigned cycle_count = 0;

  gather_stick_address_generator #(
    .MAX_DIMS(MAX_DIMS)
  ) DUT (
    .clk        (clk),
    .rst        (rst),
    .idx_valid  (idx_valid),
    .idx_stall  (idx_stall),
    .idx_item   (idx_item),
    .addr_valid (addr_valid),
    .addr_stall (addr_stall),
    .addr_item  (addr_item),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Size of one index tensor dimension; dimension 0 sits in the top bits.
  function automatic logic [15:0] shape_dim(int d);
    return shape_m[(63 - 16 * d) -: 16];
  endfunction

  // Computes the stick address for one index and steps the coordinate counter.
  function automatic addr_item_t predict_stick_address(idx_item_t item);
    logic [63:0] sum;
    logic [31:0] raw;
    logic [16:0] bumped;
    bit          carry;
    addr_item_t  res;
    if (item.restart) begin
      for (int d = 0; d < COORD_SLOTS; d++) coord_m[d] = '0;
    end
    sum = 64'(base_m);
    for (int d = 0; d < ACTIVE_DIMS; d++) begin
      if (d != int'(gdim_m)) sum += 64'(coord_m[d]) * 64'(skip_m[d]);
    end
    raw = item.index_value;
    // The bounds check wins over overflow.
    if (raw[31] || raw >= 32'(gsize_m)) begin
      res.status = STATUS_BOUNDS;
    end else begin
      sum += 64'(raw) * 64'(skip_m[gdim_m]);
      res.status = (sum > 64'hFFFF_FFFF) ? STATUS_OVERFLOW : STATUS_OK;
    end
    res.stick_address = (res.status == STATUS_OK) ? sum[31:0] : '0;
    // The last dimension counts fastest; a size of zero wraps like a size of one.
    carry = 1'b1;
    for (int d = ACTIVE_DIMS - 1; d >= 0; d--) begin
      if (carry) begin
        bumped = {1'b0, coord_m[d]} + 17'd1;
        if (bumped >= {1'b0, shape_dim(d)}) begin
          coord_m[d] = '0;
        end else begin
          coord_m[d] = bumped[15:0];
          carry = 1'b0;
        end
      end
    end
    return res;
  endfunction

  // Sender: presents queued index transfers, with the drawn gap before each.
  always @(posedge clk) begin
    if (!rst) begin
      if (idx_valid && !idx_stall) begin
        stick_addr_queue.push_back(predict_stick_address(idx_item));
        items_sent++;
      end
      if (!idx_valid || !idx_stall) begin
        if (!staged && index_fifo.size() != 0) begin
          stage = index_fifo.pop_front();
          staged = 1'b1;
        end
        if (staged && stage.gap == 0) begin
          idx_item <= stage.item;
          idx_valid <= 1'b1;
          staged = 1'b0;
        end else begin
          idx_valid <= 1'b0;
          if (staged) stage.gap--;
        end
      end
    end
  end

  // Receiver: checks each address transfer against the oldest prediction.
  always @(posedge clk) begin
    addr_item_t want;
    if (!rst) begin
      if (addr_valid && !addr_stall) begin
        if (stick_addr_queue.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t: unexpected result address=%h status=%0d", $realtime,
                     addr_item.stick_address, addr_item.status);
        end else begin
          want = stick_addr_queue.pop_front();
          results_checked++;
          case (want.status)
            STATUS_OK:       ok_seen++;
            STATUS_BOUNDS:   bounds_seen++;
            STATUS_OVERFLOW: overflow_seen++;
            default: ;
          endcase
          if (addr_item.stick_address !== want.stick_address ||
              addr_item.status !== want.status) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
              $display("%0t: mismatch expected address=%h status=%0d, got address=%h status=%0d",
                       $realtime, want.stick_address, want.status,
                       addr_item.stick_address, addr_item.status);
          end
        end
        stall_left = $urandom_range(0, stall_max);
      end
      // A requested long hold-off overrides the per-transfer stall.
      if (long_hold_left > 0) begin
        long_hold_left--;
        addr_stall <= 1'b1;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        long_hold_left = LONG_HOLD_CYCLES - 1;
        addr_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        addr_stall <= 1'b1;
      end else begin
        addr_stall <= 1'b0;
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Waits until every queued index has been sent and every address has come back.
  task automatic wait_idle();
    do begin
      @(negedge clk);
    end while (index_fifo.size() != 0 || staged || idx_valid ||
               stick_addr_queue.size() != 0);
  endtask

  // Writes one register and mirrors it; indexes above seven leave nothing changed.
  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [63:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      REG_BASE_STICK:      base_m = value[31:0];
      REG_GATHER_DIM:      gdim_m = value[1:0];
      REG_GATHER_DIM_SIZE: gsize_m = value[15:0];
      REG_SHAPE_SIZES:     shape_m = value;
      REG_DIM_SKIP_0:      skip_m[0] = value[23:0];
      REG_DIM_SKIP_1:      skip_m[1] = value[23:0];
      REG_DIM_SKIP_2:      skip_m[2] = value[23:0];
      REG_DIM_SKIP_3:      skip_m[3] = value[23:0];
      default: ;
    endcase
  endtask

  // Loads a full register set once the block has drained; random upper bits ride along.
  task automatic apply_settings(logic [31:0] base, logic [1:0] gdim, logic [15:0] gsize,
                                logic [63:0] shape, logic [23:0] s0, logic [23:0] s1,
                                logic [23:0] s2, logic [23:0] s3, bit write_unused);
    wait_idle();
    repeat (3) @(posedge clk);
    write_reg(REG_BASE_STICK, {$urandom, base});
    write_reg(REG_GATHER_DIM, {$urandom, 30'($urandom), gdim});
    write_reg(REG_GATHER_DIM_SIZE, {$urandom, 16'($urandom), gsize});
    write_reg(REG_SHAPE_SIZES, shape);
    write_reg(REG_DIM_SKIP_0, {$urandom, 8'($urandom), s0});
    write_reg(REG_DIM_SKIP_1, {$urandom, 8'($urandom), s1});
    write_reg(REG_DIM_SKIP_2, {$urandom, 8'($urandom), s2});
    write_reg(REG_DIM_SKIP_3, {$urandom, 8'($urandom), s3});
    if (write_unused)
      write_reg(CFG_INDEX_W'($urandom_range(CFG_FIRST_UNUSED, CFG_LAST_INDEX)),
                {$urandom, $urandom});
    @(posedge clk);
    cfg_write <= 1'b0;
    settings_applied++;
  endtask

  task automatic push_index(logic [31:0] value, bit restart);
    index_entry_t entry;
    entry.item.index_value = value;
    entry.item.restart = restart;
    entry.gap = $urandom_range(0, gap_max);
    index_fifo.push_back(entry);
    items_queued++;
  endtask

  // Mostly in-range indices, with edges, negatives and raw noise mixed in.
  function automatic logic [31:0] pick_index();
    case ($urandom_range(0, 9))
      0: return 32'(gsize_m);
      1: return (gsize_m == 0) ? 32'd0 : 32'(gsize_m) - 32'd1;
      2: return 32'hFFFF_FFFF - $urandom_range(0, 1000);
      3: return $urandom;
      default: return (gsize_m == 0) ? 32'd0 : $urandom_range(0, gsize_m - 1);
    endcase
  endfunction

  function automatic logic [15:0] pick_size();
    case ($urandom_range(0, 15))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom);
      default: return 16'($urandom_range(1, 5));
    endcase
  endfunction

  function automatic logic [23:0] pick_skip();
    case ($urandom_range(0, 7))
      0: return 24'd0;
      1: return 24'hFF_FFFF;
      2, 3: return 24'($urandom_range(1, 255));
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_base();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'hFFFF_FFFF - $urandom_range(0, 1 << 24);
      3: return $urandom_range(0, 4095);
      default: return $urandom;
    endcase
  endfunction

  // Random register set; the bound usually matches the gathered dimension's size.
  task automatic apply_random_settings();
    logic [15:0] sizes [COORD_SLOTS];
    logic [1:0]  gdim;
    logic [15:0] gsize;
    for (int d = 0; d < COORD_SLOTS; d++) sizes[d] = pick_size();
    gdim = 2'($urandom);
    case ($urandom_range(0, 9))
      0: gsize = 16'd0;
      1: gsize = 16'hFFFF;
      2: gsize = 16'd1;
      3: gsize = 16'($urandom);
      default: gsize = (sizes[gdim] == 0) ? 16'd1 : sizes[gdim];
    endcase
    apply_settings(pick_base(), gdim, gsize, {sizes[0], sizes[1], sizes[2], sizes[3]},
                   pick_skip(), pick_skip(), pick_skip(), pick_skip(),
                   $urandom_range(0, 3) == 0);
  endtask

  // Streams whole index tensors in row-major order, restarting at each tensor start.
  task automatic stream_tensors(int unsigned count);
    longint unsigned tensor_len;
    longint unsigned pos;
    bit              restart;
    tensor_len = 1;
    for (int d = 0; d < ACTIVE_DIMS; d++)
      tensor_len *= (shape_dim(d) == 0) ? 64'd1 : 64'(shape_dim(d));
    pos = 0;
    for (int unsigned n = 0; n < count; n++) begin
      restart = ((pos % tensor_len) == 0 && (n > 0 || $urandom_range(0, 7) != 0)) ||
                ($urandom_range(0, 39) == 0);
      if (restart) pos = 0;
      push_index(pick_index(), restart);
      pos++;
      // Sometimes the sender pauses mid-stream until everything has drained.
      if (n == count / 2 && $urandom_range(0, 3) == 0) wait_idle();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: empty shape, bound of one.
    gap_max = 5;
    stall_max = 5;
    push_index(32'd0, 1'b1);
    push_index(32'd1, 1'b0);
    push_index(32'hFFFF_FFFF, 1'b0);

    // Largest base and skips: overflow, the bound edge and the sign bit.
    apply_settings(32'hFFFF_FFFF, 2'd3, 16'hFFFF, {16'd2, 16'd0, 16'd3, 16'hFFFF},
                   24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 1'b1);
    push_index(32'd0, 1'b1);
    push_index(32'd1, 1'b0);
    push_index(32'h0000_FFFE, 1'b0);
    push_index(32'h0000_FFFF, 1'b0);
    push_index(32'h7FFF_FFFF, 1'b0);
    push_index(32'h8000_0000, 1'b0);

    // A bound of zero rejects every index.
    gap_max = 0;
    stall_max = 0;
    apply_settings(32'd0, 2'd0, 16'd0, 64'hFFFF_FFFF_FFFF_FFFF,
                   24'd0, 24'd0, 24'd0, 24'd0, 1'b0);
    push_index(32'd0, 1'b1);
    push_index(32'd5, 1'b0);

    // One full tensor with a size-zero dimension, its wrap, then a restart.
    gap_max = 2;
    stall_max = 2;
    apply_settings(32'h100, 2'd1, 16'hFFFF, {16'd3, 16'd2, 16'd0, 16'd2},
                   24'h10, 24'h100, 24'h1000, 24'h1, 1'b0);
    for (int n = 0; n < 12; n++) push_index(32'(n), n == 0);
    push_index(32'd0, 1'b0);
    push_index(32'd2, 1'b1);

    // Back-to-back transfers while the receiver holds off for a long stretch.
    gap_max = 0;
    stall_max = 0;
    apply_random_settings();
    stream_tensors(80);
    long_hold_req = 1'b1;

    // Random settings and tensors, each phase with or without idling.
    while (items_queued < TARGET_ITEMS) begin
      gap_max = ($urandom_range(0, 2) == 0) ? 0 : 5;
      stall_max = ($urandom_range(0, 2) == 0) ? 0 : 5;
      apply_random_settings();
      stream_tensors($urandom_range(16, 100));
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (stick_addr_queue.size() != 0) begin
      error_count += stick_addr_queue.size();
      $display("%0d predicted results never arrived", stick_addr_queue.size());
    end

    $display("Sent %0d index transfers under %0d register sets; checked %0d addresses.",
             items_sent, settings_applied, results_checked);
    $display("Status mix: %0d in range, %0d out of bounds, %0d overflowed; %0d mismatches.",
             ok_seen, bounds_seen, overflow_seen, error_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
